// File: sv/itwm_pkg.sv
// Package for the idle time window monitor: widths, constants, controller
// states and the command and status structs between controller and datapath.
// Depends on nothing; every other file of the block imports it.
package itwm_pkg;

    // Time and register widths.
    localparam int TIME_BITS = 48;
    localparam int WIN_BITS  = 32;
    localparam int PCT_BITS  = 7;

    // The percentage is below 128, so the quotient has PCT_BITS bits and the
    // scaled numerator acc * 100 fits in TIME_BITS + PCT_BITS bits.
    localparam int NUM_BITS  = TIME_BITS + PCT_BITS;
    localparam int DIV_STEPS = PCT_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);

    localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(1000000);
    localparam logic [PCT_BITS-1:0] PCT_FULL     = PCT_BITS'(100);
    localparam logic [CNT_BITS-1:0] CNT_LAST     = CNT_BITS'(DIV_STEPS - 1);

    // Event codes.
    localparam logic OP_IDLE_BEGIN = 1'b0;
    localparam logic OP_IDLE_END   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_EVAL,
        S_PREP,
        S_DIV,
        S_CLOSE,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap;
        logic diff;
        logic begin_idle;
        logic end_idle;
        logic open_win;
        logic add_acc;
        logic div_init;
        logic div_step;
        logic close_win;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op;
        logic idle_open;
        logic window_active;
        logic el_ge_win;
    } t_dp_sts;

endpackage

// File: sv/itwm_if.sv
// Channel interfaces of the idle time window monitor: event input, result
// output and the window length write channel. Depends on itwm_pkg.

// Event channel: one item is an idle begin or idle end with its time.
interface itwm_evt_if;
    import itwm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [TIME_BITS-1:0] timestamp_us;
    modport source (output valid, output op, output timestamp_us, input ready);
    modport sink   (input valid, input op, input timestamp_us, output ready);
endinterface

// Result channel: one item per event.
interface itwm_res_if;
    import itwm_pkg::*;
    logic                valid;
    logic                ready;
    logic [PCT_BITS-1:0] idle_percent;
    logic                percent_updated;
    logic                currently_idle;
    modport source (output valid, output idle_percent, output percent_updated,
                    output currently_idle, input ready);
    modport sink   (input valid, input idle_percent, input percent_updated,
                    input currently_idle, output ready);
endinterface

// Configuration channel: writes the window length register.
interface itwm_cfg_if;
    import itwm_pkg::*;
    logic                valid;
    logic                ready;
    logic [WIN_BITS-1:0] window_us;
    modport source (output valid, output window_us, input ready);
    modport sink   (input valid, input window_us, output ready);
endinterface

// File: sv/itwm_ctrl.sv
// Controller of the idle time window monitor: sequences one event through
// the datapath and owns the result valid flag. Depends on itwm_pkg.
module itwm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  itwm_pkg::t_dp_sts i_sts,
    output itwm_pkg::t_dp_cmd o_cmd
);
    import itwm_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;

    // State, step counter and result valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_OUT;
                if (i_sts.op == OP_IDLE_BEGIN) begin
                    o_cmd.begin_idle = !i_sts.idle_open;
                end else if (i_sts.idle_open) begin
                    o_cmd.end_idle = 1'b1;
                    if (!i_sts.window_active) begin
                        o_cmd.open_win = 1'b1;
                    end else begin
                        o_cmd.add_acc = 1'b1;
                        if (i_sts.el_ge_win) begin
                            n_state = S_PREP;
                        end
                    end
                end
            end
            S_PREP: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE: begin
                o_cmd.close_win = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A result stays valid until taken; a new one is loaded only into a free slot.
    assign n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.load_out;
    assign o_out_valid = r_out_valid;

endmodule

// File: sv/itwm_dp.sv
// Datapath of the idle time window monitor: time state, window accumulator,
// window length register, restoring divider and result register.
// Depends on itwm_pkg.
module itwm_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [itwm_pkg::WIN_BITS-1:0] i_cfg_window_us,
    input  logic                          i_op,
    input  logic [itwm_pkg::TIME_BITS-1:0] i_timestamp_us,
    input  itwm_pkg::t_dp_cmd             i_cmd,
    output itwm_pkg::t_dp_sts             o_sts,
    output logic [itwm_pkg::PCT_BITS-1:0] o_idle_percent,
    output logic                          o_percent_updated,
    output logic                          o_currently_idle
);
    import itwm_pkg::*;

    // Captured event and time differences.
    logic                 r_op;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_dur;
    logic [TIME_BITS-1:0] r_el;

    // Monitor state.
    logic [WIN_BITS-1:0]  r_win;
    logic                 r_open;
    logic                 r_active;
    logic [TIME_BITS-1:0] r_ibegin;
    logic [TIME_BITS-1:0] r_wbegin;
    logic [TIME_BITS-1:0] r_acc;
    logic [PCT_BITS-1:0]  r_pct;
    logic                 r_upd;

    // Divider state.
    logic [NUM_BITS-1:0]  r_rem;
    logic [NUM_BITS-1:0]  r_div;
    logic [PCT_BITS-1:0]  r_quo;
    logic                 r_zero;
    logic                 r_full;

    // Result register.
    logic [PCT_BITS-1:0]  r_o_pct;
    logic                 r_o_upd;
    logic                 r_o_idle;

    logic [NUM_BITS-1:0]  acc_x100;
    logic                 rem_ge;
    logic [PCT_BITS-1:0]  pct_new;

    // acc * 100 as three shifted terms.
    assign acc_x100 = (NUM_BITS'(r_acc) << 6) + (NUM_BITS'(r_acc) << 5)
                    + (NUM_BITS'(r_acc) << 2);
    assign rem_ge   = (r_rem >= r_div);

    // Zero elapsed time gives 0, an accumulator not below elapsed gives 100.
    always_comb begin
        priority if (r_zero) begin
            pct_new = '0;
        end else if (r_full) begin
            pct_new = PCT_FULL;
        end else begin
            pct_new = r_quo;
        end
    end

    // Control state and the window length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= WINDOW_RESET;
            r_open   <= 1'b0;
            r_active <= 1'b0;
            r_ibegin <= '0;
            r_wbegin <= '0;
            r_acc    <= '0;
            r_pct    <= '0;
            r_upd    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_win <= i_cfg_window_us;
            end
            if (i_cmd.cap) begin
                r_upd <= 1'b0;
            end
            if (i_cmd.begin_idle) begin
                r_ibegin <= r_now;
                r_open   <= 1'b1;
            end
            if (i_cmd.end_idle) begin
                r_open <= 1'b0;
            end
            if (i_cmd.open_win) begin
                r_wbegin <= r_now;
                r_acc    <= '0;
                r_active <= 1'b1;
            end else if (i_cmd.add_acc) begin
                r_acc <= r_acc + r_dur;
            end
            if (i_cmd.close_win) begin
                r_pct    <= pct_new;
                r_wbegin <= r_now;
                r_acc    <= '0;
                r_upd    <= 1'b1;
            end
        end
    end

    // Event capture, differences, divider and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op  <= i_op;
            r_now <= i_timestamp_us;
        end
        if (i_cmd.diff) begin
            r_dur <= r_now - r_ibegin;
            r_el  <= r_now - r_wbegin;
        end
        if (i_cmd.div_init) begin
            r_rem  <= acc_x100;
            r_div  <= NUM_BITS'(r_el) << (DIV_STEPS - 1);
            r_quo  <= '0;
            r_zero <= (r_el == '0);
            r_full <= (r_acc >= r_el);
        end else if (i_cmd.div_step) begin
            if (rem_ge) begin
                r_rem <= r_rem - r_div;
            end
            r_div <= r_div >> 1;
            r_quo <= {r_quo[PCT_BITS-2:0], rem_ge};
        end
        if (i_cmd.load_out) begin
            r_o_pct  <= r_pct;
            r_o_upd  <= r_upd;
            r_o_idle <= r_open;
        end
    end

    assign o_sts.op            = r_op;
    assign o_sts.idle_open     = r_open;
    assign o_sts.window_active = r_active;
    assign o_sts.el_ge_win     = (r_el >= TIME_BITS'(r_win));

    assign o_idle_percent    = r_o_pct;
    assign o_percent_updated = r_o_upd;
    assign o_currently_idle  = r_o_idle;

endmodule

// File: sv/idle_time_window_monitor.sv
// Idle time window monitor, top level: controller, datapath and channels.
// An event runs through the capture, difference, evaluate and output steps;
// one that closes a window adds setup, 7 restoring divide steps of one quotient
// bit each, then the close. The next event is taken only after the output step,
// and a result still held by the receiver stalls an event at its output step.
// Reset (i_rst_n, synchronous, active low): state clear, window 1000000 us.
module idle_time_window_monitor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    itwm_evt_if.sink          i_evt,
    itwm_res_if.source        o_res,
    itwm_cfg_if.sink          i_cfg
);
    import itwm_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // The window length register takes a write in any cycle.
    assign i_cfg.ready = 1'b1;

    itwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_evt.valid),
        .o_in_ready  (i_evt.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    itwm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg.valid),
        .i_cfg_window_us   (i_cfg.window_us),
        .i_op              (i_evt.op),
        .i_timestamp_us    (i_evt.timestamp_us),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_idle_percent    (o_res.idle_percent),
        .o_percent_updated (o_res.percent_updated),
        .o_currently_idle  (o_res.currently_idle)
    );

`ifndef SYNTH
    // The percentage never exceeds 100.
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.idle_percent <= PCT_FULL))
        else $error("idle percentage above 100");

    // One event at a time: no accept in the cycle after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt.valid && i_evt.ready) |=> !i_evt.ready)
        else $error("event accepted while another is in work");

    // A window closes only on an idle end, so the block is not idle then.
    a_close_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.percent_updated) |-> !o_res.currently_idle)
        else $error("window closed while an idle period is open");
`endif

endmodule

// File: bench/idle_time_window_monitor_checker.sv
`timescale 1ns / 100ps
// Checker for the idle time window monitor: watches the event, result and
// window length channels, predicts each result and compares it field by field.
// Depends on itwm_pkg and the channel interfaces in itwm_if.sv.
module idle_time_window_monitor_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    itwm_evt_if  i_evt,
    itwm_res_if  i_res,
    itwm_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import itwm_pkg::*;

    // One predicted result item.
    typedef struct {
        logic [PCT_BITS-1:0] percent;
        logic                updated;
        logic                idle;
    } t_idle_report;

    // Predicted state of the monitor.
    logic [WIN_BITS-1:0]  window_len;
    logic                 idle_now;
    logic [TIME_BITS-1:0] idle_since;
    logic [TIME_BITS-1:0] window_since;
    logic [TIME_BITS-1:0] idle_total;
    logic                 window_open;
    logic [PCT_BITS-1:0]  last_percent;

    t_idle_report expected_reports[$];
    int           mismatches = 0;

    // Idle share of a window in whole percent, capped at 100.
    function automatic logic [PCT_BITS-1:0] window_percent(logic [TIME_BITS-1:0] acc,
                                                           logic [TIME_BITS-1:0] span);
        logic [63:0] scaled;
        if (span == '0)
            return '0;
        if (acc >= span)
            return PCT_FULL;
        scaled = 64'(acc) * 64'd100;
        return PCT_BITS'(scaled / 64'(span));
    endfunction

    // Advances the predicted state by one event and returns its result.
    function automatic t_idle_report apply_idle_event(logic op, logic [TIME_BITS-1:0] stamp);
        t_idle_report         rep;
        logic [TIME_BITS-1:0] span;
        rep.updated = 1'b0;
        if (op == OP_IDLE_BEGIN) begin
            if (!idle_now) begin
                idle_since = stamp;
                idle_now   = 1'b1;
            end
        end else if (idle_now) begin
            idle_total = idle_total + (stamp - idle_since);
            idle_now   = 1'b0;
            if (!window_open) begin
                // The first closed idle period only starts the window.
                window_since = stamp;
                idle_total   = '0;
                window_open  = 1'b1;
            end else begin
                span = stamp - window_since;
                if (span >= TIME_BITS'(window_len)) begin
                    last_percent = window_percent(idle_total, span);
                    window_since = stamp;
                    idle_total   = '0;
                    rep.updated  = 1'b1;
                end
            end
        end
        rep.percent = last_percent;
        rep.idle    = idle_now;
        return rep;
    endfunction

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Predict on every accepted event, check on every accepted result.
    always @(posedge i_clk) begin : check_proc
        t_idle_report want;
        if (!i_rst_n) begin
            window_len   = WINDOW_RESET;
            idle_now     = 1'b0;
            idle_since   = '0;
            window_since = '0;
            idle_total   = '0;
            window_open  = 1'b0;
            last_percent = '0;
            expected_reports.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                window_len = i_cfg.window_us;
            if (i_res.valid && i_res.ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: result with no event waiting: percent %0d updated %0b idle %0b",
                             $time, i_res.idle_percent, i_res.percent_updated,
                             i_res.currently_idle);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    compare_field("idle_percent", want.percent, i_res.idle_percent);
                    compare_field("percent_updated", want.updated, i_res.percent_updated);
                    compare_field("currently_idle", want.idle, i_res.currently_idle);
                end
            end
            if (i_evt.valid && i_evt.ready)
                expected_reports.push_back(apply_idle_event(i_evt.op, i_evt.timestamp_us));
        end
        o_pending    <= expected_reports.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: bench/idle_time_window_monitor_tb.sv
`timescale 1ns / 100ps
// Testbench top for the idle time window monitor: clock, reset, event and
// window length stimulus, result back-pressure, watchdog and the verdict.
// Depends on itwm_pkg, itwm_if.sv, the block and the checker module.
module idle_time_window_monitor_tb;
    import itwm_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_EVENTS   = 162;
    localparam int PHASE_COUNT    = 12;

    logic i_clk = 1'b0;
    logic i_rst_n;

    itwm_evt_if evt_ch ();
    itwm_res_if res_ch ();
    itwm_cfg_if cfg_ch ();

    int fail_count;
    int pending;

    // Stimulus controls shared with the result ready process.
    bit rx_jitter = 1'b0;
    int hold_asks = 0;
    int holds_done = 0;

    int                   quiet_cycles = 0;
    logic [TIME_BITS-1:0] now_us = '0;
    logic [TIME_BITS-1:0] win_start;

    idle_time_window_monitor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    idle_time_window_monitor_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (evt_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [TIME_BITS-1:0] random_stamp();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Offers one event, with an optional random gap first, and waits for it.
    task automatic send_event(logic op, logic [TIME_BITS-1:0] stamp, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0) begin
            evt_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        evt_ch.valid        <= 1'b1;
        evt_ch.op           <= op;
        evt_ch.timestamp_us <= stamp;
        @(posedge i_clk);
        while (!evt_ch.ready) @(posedge i_clk);
    endtask

    // Waits until every result has come back and the block has settled.
    task automatic drain_results();
        evt_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_window(logic [WIN_BITS-1:0] value);
        drain_results();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.window_us <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Window lengths sized to the time steps of each scale, extremes now and then.
    function automatic logic [WIN_BITS-1:0] pick_window(int scale);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return (scale == 2) ? '1 : WIN_BITS'(1);
            default: begin
                case (scale)
                    0: return WIN_BITS'($urandom_range(0, 200));
                    1: return WIN_BITS'($urandom_range(0, 1 << 22));
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // Mostly alternating begin and end events with advancing time, some noise.
    task automatic run_random_phase(int scale, bit gaps);
        logic                 op;
        logic                 next_op;
        logic [TIME_BITS-1:0] stamp;
        next_op = OP_IDLE_BEGIN;
        for (int i = 0; i < PHASE_EVENTS; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                op    = 1'($urandom);
                stamp = $urandom_range(0, 1) ? random_stamp() : now_us;
            end else begin
                case (scale)
                    0: now_us = now_us + TIME_BITS'($urandom_range(0, 40));
                    1: now_us = now_us + TIME_BITS'($urandom_range(0, 1 << 20));
                    default: now_us = now_us + random_stamp();
                endcase
                op      = next_op;
                stamp   = now_us;
                next_op = ~next_op;
            end
            send_event(op, stamp, gaps);
        end
    endtask

    // Result side back-pressure: random stalls, plus long hold-offs on request.
    initial begin : result_ready_proc
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (holds_done != hold_asks) begin
                holds_done++;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_jitter && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Ends the run when nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main stimulus and verdict.
    initial begin : stimulus_proc
        bit gaps;
        i_rst_n             <= 1'b0;
        evt_ch.valid        <= 1'b0;
        evt_ch.op           <= OP_IDLE_BEGIN;
        evt_ch.timestamp_us <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.window_us    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset window length: stray end, repeated begin, window opening, first close.
        rx_jitter = 1'b1;
        send_event(OP_IDLE_END, 48'd0, 1'b1);
        send_event(OP_IDLE_BEGIN, 48'd10, 1'b1);
        send_event(OP_IDLE_BEGIN, 48'd20, 1'b1);
        send_event(OP_IDLE_END, 48'd110, 1'b1);
        send_event(OP_IDLE_BEGIN, 48'd200, 1'b1);
        send_event(OP_IDLE_END, 48'd300000, 1'b1);
        send_event(OP_IDLE_BEGIN, 48'd1000000, 1'b1);
        send_event(OP_IDLE_END, 48'd1000110, 1'b1);
        send_event(OP_IDLE_END, 48'd1000200, 1'b1);

        // Zero window: zero elapsed time, then a fully idle window.
        write_window('0);
        send_event(OP_IDLE_BEGIN, 48'd1000110, 1'b1);
        send_event(OP_IDLE_END, 48'd1000110, 1'b1);
        send_event(OP_IDLE_BEGIN, 48'd1000110, 1'b1);
        send_event(OP_IDLE_END, 48'd1000210, 1'b1);

        // Longest window: the accumulator wraps before the window closes, then
        // an idle period across the timestamp wrap.
        write_window('1);
        win_start = 48'd1000210;
        send_event(OP_IDLE_BEGIN, win_start + 48'h8000_0000_0000, 1'b1);
        send_event(OP_IDLE_END, win_start + 48'd5, 1'b1);
        send_event(OP_IDLE_BEGIN, win_start + 48'h8000_0000_0000, 1'b1);
        send_event(OP_IDLE_END, win_start + 48'd5, 1'b1);
        send_event(OP_IDLE_BEGIN, win_start + 48'h2_0000_0000 - 48'd100, 1'b1);
        send_event(OP_IDLE_END, win_start + 48'h2_0000_0000, 1'b1);
        send_event(OP_IDLE_BEGIN, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_event(OP_IDLE_END, 48'h0, 1'b1);

        // Random phases, each with its own window length and idling pattern.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            write_window(pick_window(ph % 3));
            gaps      = (ph < PHASE_COUNT - 2) && (ph != 5) && (ph != 2);
            rx_jitter = (ph < PHASE_COUNT - 2) && (ph != 5);
            if (ph == 2)
                hold_asks++;
            run_random_phase(ph % 3, gaps);
        end

        drain_results();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
